>>> rtl/rucst_pkg.sv
package rucst_pkg;

  // Coordinate and working widths
  localparam int unsigned COORD_W = 32;
  localparam int unsigned EXT_W   = COORD_W + 2;   // signed differences and numerators
  localparam int unsigned MAG_W   = COORD_W + 1;   // magnitudes of numerators and divisors
  localparam int unsigned AXES    = 3;
  localparam int unsigned LANES   = 2 * AXES;      // entry and exit quotient for each axis
  localparam int unsigned PARAM_W = 32;

  localparam logic [PARAM_W-1:0] PARAM_MAX  = '1;
  localparam logic [31:0]        PIXEL_HIT  = 32'hFFFF_FFFF;
  localparam logic [31:0]        PIXEL_MISS = 32'hFF00_0000;

  // Per-item flags carried beside the quotients
  // lane 2k is the entry plane of axis k, lane 2k+1 the exit plane
  typedef struct packed {
    logic [AXES-1:0]  zero_dir;  // direction component is zero
    logic [AXES-1:0]  in_slab;   // start lies within the slab, bounds included
    logic [LANES-1:0] neg;       // numerator is negative
  } side_t;

  typedef struct packed {
    logic               hit;
    logic [PARAM_W-1:0] t_enter;
    logic [PARAM_W-1:0] t_exit;
  } result_t;

endpackage

>>> rtl/ray_unit_cube_slab_test_top.sv
// Channel   Direction  Handshake                  Payload
// input     in         in_valid_i / in_stall_o    start_x/y/z_i, end_x/y/z_i
// output    out        out_valid_o / out_stall_i  hit_o, t_enter_o, t_exit_o, pixel_argb_o
//
// One ray per cycle sustained while in_stall_o is low; the restoring divider decides one
// quotient bit per stage.
// Reset clears only the valid bits; no clearing pass is needed.
// A result held by out_stall_i lets one more result land in a skid register;
// the pipeline and in_stall_o then freeze until the skid register drains.
module ray_unit_cube_slab_test_top
  import rucst_pkg::*;
#(
  parameter int unsigned COORD_FRAC_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [COORD_W-1:0] start_x_i,
  input  logic signed [COORD_W-1:0] start_y_i,
  input  logic signed [COORD_W-1:0] start_z_i,
  input  logic signed [COORD_W-1:0] end_x_i,
  input  logic signed [COORD_W-1:0] end_y_i,
  input  logic signed [COORD_W-1:0] end_z_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      hit_o,
  output logic [PARAM_W-1:0]        t_enter_o,
  output logic [PARAM_W-1:0]        t_exit_o,
  output logic [31:0]               pixel_argb_o
);

  localparam int unsigned QW = MAG_W + COORD_FRAC_BITS;

  logic                      en;
  logic signed [COORD_W-1:0] start_w [AXES];
  logic signed [COORD_W-1:0] end_w   [AXES];

  logic             prep_vld;
  logic [MAG_W-1:0] prep_num [LANES];
  logic [MAG_W-1:0] prep_den [LANES];
  side_t            prep_side;

  logic             div_vld;
  logic [QW-1:0]    div_quo [LANES];
  side_t            div_side;

  logic             pipe_vld;
  result_t          pipe_res;

  logic             out_vld_q, out_vld_d;
  result_t          out_res_q, out_res_d;
  logic             skid_vld_q, skid_vld_d;
  result_t          skid_res_q, skid_res_d;
  logic             take;

  // Gather coordinates per axis
  always_comb begin
    start_w[0] = start_x_i;
    start_w[1] = start_y_i;
    start_w[2] = start_z_i;
    end_w[0]   = end_x_i;
    end_w[1]   = end_y_i;
    end_w[2]   = end_z_i;
  end

  // Freeze the whole pipeline while the skid register is occupied
  assign en         = ~skid_vld_q;
  assign in_stall_o = skid_vld_q;

  rucst_prep #(
    .FRAC_BITS (COORD_FRAC_BITS)
  ) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .start_i (start_w),
    .end_i   (end_w),
    .valid_o (prep_vld),
    .num_o   (prep_num),
    .den_o   (prep_den),
    .side_o  (prep_side)
  );

  rucst_div_pipe #(
    .FRAC_BITS (COORD_FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (prep_vld),
    .num_i   (prep_num),
    .den_i   (prep_den),
    .side_i  (prep_side),
    .valid_o (div_vld),
    .quo_o   (div_quo),
    .side_o  (div_side)
  );

  rucst_combine #(
    .FRAC_BITS (COORD_FRAC_BITS)
  ) u_combine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (div_vld),
    .quo_i   (div_quo),
    .side_i  (div_side),
    .valid_o (pipe_vld),
    .res_o   (pipe_res)
  );

  // Route results into the output register, or the skid register when held
  always_comb begin
    out_vld_d  = out_vld_q;
    out_res_d  = out_res_q;
    skid_vld_d = skid_vld_q;
    skid_res_d = skid_res_q;
    take       = out_vld_q && !out_stall_i;
    if (skid_vld_q) begin
      if (take) begin
        out_vld_d  = 1'b1;
        out_res_d  = skid_res_q;
        skid_vld_d = 1'b0;
      end
    end else if (!out_vld_q || take) begin
      out_vld_d = pipe_vld;
      out_res_d = pipe_res;
    end else if (pipe_vld) begin
      skid_vld_d = 1'b1;
      skid_res_d = pipe_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q  <= out_res_d;
    skid_res_q <= skid_res_d;
  end

  assign out_valid_o  = out_vld_q;
  assign hit_o        = out_res_q.hit;
  assign t_enter_o    = out_res_q.t_enter;
  assign t_exit_o     = out_res_q.t_exit;
  assign pixel_argb_o = out_res_q.hit ? PIXEL_HIT : PIXEL_MISS;

endmodule

>>> rtl/rucst_prep.sv
module rucst_prep
  import rucst_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic signed [COORD_W-1:0] start_i [AXES],
  input  logic signed [COORD_W-1:0] end_i   [AXES],
  output logic                      valid_o,
  output logic [MAG_W-1:0]          num_o   [LANES],
  output logic [MAG_W-1:0]          den_o   [LANES],
  output side_t                     side_o
);

  localparam logic signed [EXT_W-1:0] HALF = EXT_W'(1) << (FRAC_BITS - 1);

  logic signed [EXT_W-1:0] s_w  [AXES];
  logic signed [EXT_W-1:0] e_w  [AXES];
  logic signed [EXT_W-1:0] d_w  [AXES];
  logic signed [EXT_W-1:0] na_w [AXES];
  logic signed [EXT_W-1:0] nb_w [AXES];
  logic signed [EXT_W-1:0] dm_w [AXES];
  logic [MAG_W-1:0]        num_d [LANES];
  logic [MAG_W-1:0]        den_d [LANES];
  side_t                   side_d;

  logic             valid_q;
  logic [MAG_W-1:0] num_q [LANES];
  logic [MAG_W-1:0] den_q [LANES];
  side_t            side_q;

  // Form plane numerators and a non-negative divisor per axis
  always_comb begin
    side_d = '0;
    for (int k = 0; k < AXES; k++) begin
      s_w[k] = {{(EXT_W - COORD_W){start_i[k][COORD_W-1]}}, start_i[k]};
      e_w[k] = {{(EXT_W - COORD_W){end_i[k][COORD_W-1]}}, end_i[k]};
      d_w[k] = e_w[k] - s_w[k];
      if (d_w[k][EXT_W-1]) begin
        // negative direction: flip signs, planes swap order
        na_w[k] = s_w[k] - HALF;
        nb_w[k] = s_w[k] + HALF;
        dm_w[k] = -d_w[k];
      end else begin
        na_w[k] = -HALF - s_w[k];
        nb_w[k] = HALF - s_w[k];
        dm_w[k] = d_w[k];
      end
      num_d[2*k]       = (!na_w[k][EXT_W-1]) ? na_w[k][MAG_W-1:0] : '0;
      num_d[2*k+1]     = (!nb_w[k][EXT_W-1]) ? nb_w[k][MAG_W-1:0] : '0;
      den_d[2*k]       = dm_w[k][MAG_W-1:0];
      den_d[2*k+1]     = dm_w[k][MAG_W-1:0];
      side_d.neg[2*k]   = na_w[k][EXT_W-1];
      side_d.neg[2*k+1] = nb_w[k][EXT_W-1];
      side_d.zero_dir[k] = (d_w[k] == '0);
      side_d.in_slab[k]  = (s_w[k] >= -HALF) && (s_w[k] <= HALF);
    end
  end

  // Advance the valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // Capture the payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q  <= num_d;
      den_q  <= den_d;
      side_q <= side_d;
    end
  end

  assign valid_o = valid_q;
  assign num_o   = num_q;
  assign den_o   = den_q;
  assign side_o  = side_q;

endmodule

>>> rtl/rucst_div_pipe.sv
module rucst_div_pipe
  import rucst_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic [MAG_W-1:0]                num_i [LANES],
  input  logic [MAG_W-1:0]                den_i [LANES],
  input  side_t                           side_i,
  output logic                            valid_o,
  output logic [MAG_W+FRAC_BITS-1:0]      quo_o [LANES],
  output side_t                           side_o
);

  localparam int unsigned QW     = MAG_W + FRAC_BITS;
  localparam int unsigned STAGES = QW;

  // Stage g register holds the state after quotient bit g is decided
  logic [STAGES-1:0] vld_q;
  logic [MAG_W-1:0]  rem_q [STAGES][LANES];
  logic [MAG_W-1:0]  den_q [STAGES][LANES];
  logic [QW-1:0]     dq_q  [STAGES][LANES];
  side_t             side_q [STAGES];

  logic [MAG_W-1:0]  cur_rem [STAGES][LANES];
  logic [MAG_W-1:0]  cur_den [STAGES][LANES];
  logic [QW-1:0]     cur_dq  [STAGES][LANES];
  side_t             cur_side [STAGES];
  logic [MAG_W-1:0]  nxt_rem [STAGES][LANES];
  logic [QW-1:0]     nxt_dq  [STAGES][LANES];

  // Select each stage's source: the inputs for the first, else the previous register
  always_comb begin
    cur_side[0] = side_i;
    for (int l = 0; l < LANES; l++) begin
      cur_rem[0][l] = '0;
      cur_den[0][l] = den_i[l];
      cur_dq[0][l]  = {num_i[l], {FRAC_BITS{1'b0}}};
    end
    for (int g = 1; g < STAGES; g++) begin
      cur_side[g] = side_q[g-1];
      for (int l = 0; l < LANES; l++) begin
        cur_rem[g][l] = rem_q[g-1][l];
        cur_den[g][l] = den_q[g-1][l];
        cur_dq[g][l]  = dq_q[g-1][l];
      end
    end
  end

  // One restoring step per stage: shift in a dividend bit, trial subtract
  always_comb begin
    logic [MAG_W:0] r2;
    logic [MAG_W:0] diff;
    for (int g = 0; g < STAGES; g++) begin
      for (int l = 0; l < LANES; l++) begin
        r2   = {cur_rem[g][l], cur_dq[g][l][QW-1]};
        diff = r2 - {1'b0, cur_den[g][l]};
        nxt_rem[g][l] = diff[MAG_W] ? r2[MAG_W-1:0] : diff[MAG_W-1:0];
        nxt_dq[g][l]  = {cur_dq[g][l][QW-2:0], ~diff[MAG_W]};
      end
    end
  end

  // Shift the valid bits along with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[STAGES-2:0], valid_i};
    end
  end

  // Advance every stage together
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int g = 0; g < STAGES; g++) begin
        side_q[g] <= cur_side[g];
        for (int l = 0; l < LANES; l++) begin
          rem_q[g][l] <= nxt_rem[g][l];
          den_q[g][l] <= cur_den[g][l];
          dq_q[g][l]  <= nxt_dq[g][l];
        end
      end
    end
  end

  assign valid_o = vld_q[STAGES-1];
  assign quo_o   = dq_q[STAGES-1];
  assign side_o  = side_q[STAGES-1];

endmodule

>>> rtl/rucst_combine.sv
module rucst_combine
  import rucst_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [MAG_W+FRAC_BITS-1:0] quo_i [LANES],
  input  side_t                      side_i,
  output logic                       valid_o,
  output result_t                    res_o
);

  localparam int unsigned QW = MAG_W + FRAC_BITS;
  localparam int unsigned TW = QW + 2;
  localparam logic signed [TW-1:0] T_INF  = {2'b01, {QW{1'b0}}};
  localparam logic signed [TW-1:0] T_NEG1 = '1;
  localparam logic signed [TW-1:0] T_MAX  = {{(TW - PARAM_W){1'b0}}, PARAM_MAX};

  logic signed [TW-1:0] t_w [LANES];
  logic                 ok_w;
  logic [2:0]           vld_q;

  // first stage: pairwise max of entries, min of exits
  logic signed [TW-1:0] e01_q, e2_q, x01_q, x2_q;
  logic                 ok1_q;
  // second stage: final range
  logic signed [TW-1:0] lo_q, hi_q;
  logic                 ok2_q;
  result_t              res_q;
  result_t              res_d;

  // Map each lane to a signed parameter: unrestricted, negative or quotient
  always_comb begin
    ok_w = 1'b1;
    for (int l = 0; l < LANES; l++) begin
      if (side_i.zero_dir[l/2]) begin
        t_w[l] = (l % 2 == 0) ? '0 : T_INF;
      end else if (side_i.neg[l]) begin
        t_w[l] = T_NEG1;
      end else begin
        t_w[l] = {2'b00, quo_i[l]};
      end
    end
    for (int k = 0; k < AXES; k++) begin
      if (side_i.zero_dir[k] && !side_i.in_slab[k]) begin
        ok_w = 1'b0;
      end
    end
  end

  // Clip, compare and pack the result
  always_comb begin
    res_d.hit     = ok2_q && (lo_q <= hi_q);
    res_d.t_enter = (lo_q > T_MAX) ? PARAM_MAX : lo_q[PARAM_W-1:0];
    if (!ok2_q || hi_q[TW-1]) begin
      res_d.t_exit = '0;
    end else if (hi_q > T_MAX) begin
      res_d.t_exit = PARAM_MAX;
    end else begin
      res_d.t_exit = hi_q[PARAM_W-1:0];
    end
  end

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  // Reduce over the axes in two levels, then register the result
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e01_q <= (t_w[0] > t_w[2]) ? t_w[0] : t_w[2];
      e2_q  <= t_w[4][TW-1] ? '0 : t_w[4];
      x01_q <= (t_w[1] < t_w[3]) ? t_w[1] : t_w[3];
      x2_q  <= t_w[5];
      ok1_q <= ok_w;
      lo_q  <= (e01_q > e2_q) ? e01_q : e2_q;
      hi_q  <= (x01_q < x2_q) ? x01_q : x2_q;
      ok2_q <= ok1_q;
      res_q <= res_d;
    end
  end

  assign valid_o = vld_q[2];
  assign res_o   = res_q;

endmodule
